// ===== rtl/can_packet_fragmenter_core_macros.svh =====
// Assertion macros for the CAN packet fragmenter core.
`ifndef CAN_PACKET_FRAGMENTER_CORE_MACROS_SVH
`define CAN_PACKET_FRAGMENTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define CPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define CPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/cpf_pkg.sv =====
// Shared types and constants for the CAN packet fragmenter core.
package cpf_pkg;

    localparam int MAX_PAYLOAD = 255;
    localparam int FRAME_BYTES = 8;
    localparam int HDR_BYTES   = 1 + 1 + 1;
    localparam int CK_BYTES    = 4;

    localparam int ADDR_W  = 8;
    localparam int DST_DEPTH = 1 << ADDR_W;
    localparam int CTR_W   = 3;
    localparam int FRAG_W  = 7;
    localparam int ID_W    = 29;
    localparam int DATA_W  = 8 * FRAME_BYTES;
    localparam int EXT_W   = DATA_W + 8 * CK_BYTES;
    localparam int CNT_W   = $clog2(FRAME_BYTES + CK_BYTES + 1);
    localparam int LEN_W   = 4;
    localparam int PLEN_W  = 8;
    localparam int REM_W   = $clog2(MAX_PAYLOAD + 1);

    localparam logic [ID_W-1:0] END_BIT = ID_W'(32'h0400);
    localparam logic [1:0]      HLEN    = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 104;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_DATA  = 1'b1
    } cpf_op_t;

    // Input beat payload, first field in the high bits.
    typedef struct packed {
        logic [7:0]        payload_byte;
        logic [31:0]       checksum;
        logic [PLEN_W-1:0] pay_len;
        logic [7:0]        dport;
        logic [7:0]        sport;
        logic [3:0]        ttl;
        logic [1:0]        flags;
        logic [1:0]        priority_req;
        logic [ADDR_W-1:0] dst_node;
        logic [ADDR_W-1:0] src_node;
    } cpf_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_data;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_run;
    } cpf_frame_t;

endpackage

// ===== rtl/cpf_out_fifo.sv =====
// Four-entry result queue, takes up to two frames per cycle.
module cpf_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  cpf_pkg::cpf_frame_t push_a,
    input  cpf_pkg::cpf_frame_t push_b,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output cpf_pkg::cpf_frame_t out_beat
);

    cpf_pkg::cpf_frame_t entry_reg [cpf_pkg::FIFO_DEPTH];
    logic [cpf_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cpf_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cpf_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [cpf_pkg::FIFO_PTR_W-1:0] wr_ptr_b;
    logic                           pop;

    assign out_valid = (cnt_reg != '0);
    assign out_beat  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= cpf_pkg::FIFO_CNT_W'(cpf_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + cpf_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + cpf_pkg::FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + cpf_pkg::FIFO_CNT_W'(push_cnt)
                      - cpf_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < cpf_pkg::FIFO_DEPTH; i++) begin
            if (push_cnt != 2'd0 && wr_ptr_reg == cpf_pkg::FIFO_PTR_W'(i)) begin
                entry_reg[i] <= push_a;
            end else if (push_cnt == 2'd2 && wr_ptr_b == cpf_pkg::FIFO_PTR_W'(i)) begin
                entry_reg[i] <= push_b;
            end
        end
    end

endmodule

// ===== rtl/can_packet_fragmenter_core.sv =====
// Top level of the CAN packet fragmenter: packet stream in, extended-ID CAN frames out.
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+-------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | begin (header fields, CRC) or one payload byte
//  m_*     | out | m_tvalid/m_tready  | one CAN frame: 29-bit ID, up to 8 bytes, length
//
//  One input beat per cycle while the result queue has room. A taken beat is registered along
//  with the read of its packet counter from a 256 x 3 synchronous RAM; the stage then does the
//  read-modify-write, with forwarding, and the byte packing, and its frames go to m_* through
//  the result queue. A payload byte that closes a packet can emit two frames; the held beat
//  waits, and s_tready drops, while the result queue holds more than two frames. Reset
//  (aresetn, synchronous) clears the counter table at once through per-entry valid bits.

`include "can_packet_fragmenter_core_macros.svh"

module can_packet_fragmenter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_node[7:0], dst_node[15:8], priority_req[17:16], flags[19:18], ttl[23:20],
    // sport[31:24], dport[39:32], pay_len[47:40], checksum[79:48],
    // payload_byte[87:80]
    input  logic [cpf_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                              s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_id[28:0], frame_data[92:29], frame_length[96:93], zero fill [103:97]
    output logic [cpf_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_of_run
    output logic                              m_tlast
);

    // ---------------------------------------------------------------------
    // Input stage register
    // ---------------------------------------------------------------------
    cpf_pkg::cpf_item_t s_item;
    cpf_pkg::cpf_item_t s1_item_reg;
    cpf_pkg::cpf_op_t   s1_op_reg;
    logic               s1_vld_reg;
    logic               s1_fire;
    logic               fifo_room;

    assign s_item   = cpf_pkg::cpf_item_t'(s_tdata);
    assign s1_fire  = s1_vld_reg && fifo_room;
    assign s_tready = !s1_vld_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_tready) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_item_reg <= s_item;
            s1_op_reg   <= cpf_pkg::cpf_op_t'(s_tuser);
        end
    end

    // ---------------------------------------------------------------------
    // Packet counter table: one read and one write port, read data registered.
    // While the stage is stalled the held beat's address is read again, so the
    // registered data is always for the beat in the stage. A write in the cycle
    // the next beat's read is issued is forwarded.
    // ---------------------------------------------------------------------
    logic [cpf_pkg::CTR_W-1:0]     ctr_mem [cpf_pkg::DST_DEPTH];
    logic [cpf_pkg::CTR_W-1:0]     ctr_rd_reg;
    logic [cpf_pkg::ADDR_W-1:0]    ctr_rd_addr;
    logic [cpf_pkg::DST_DEPTH-1:0] ctr_vld_reg;
    logic                          ctr_wr_en;
    logic [cpf_pkg::CTR_W-1:0]     ctr_cur;
    logic [cpf_pkg::CTR_W-1:0]     ctr_new;
    logic                          fwd_vld_reg;
    logic [cpf_pkg::ADDR_W-1:0]    fwd_addr_reg;
    logic [cpf_pkg::CTR_W-1:0]     fwd_data_reg;

    assign ctr_rd_addr = s_tready ? s_item.dst_node : s1_item_reg.dst_node;

    always_ff @(posedge aclk) begin
        if (ctr_wr_en) begin
            ctr_mem[s1_item_reg.dst_node] <= ctr_new;
        end
        ctr_rd_reg <= ctr_mem[ctr_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
        end else begin
            if (ctr_wr_en) begin
                ctr_vld_reg[s1_item_reg.dst_node] <= 1'b1;
            end
            fwd_vld_reg <= ctr_wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctr_wr_en) begin
            fwd_addr_reg <= s1_item_reg.dst_node;
            fwd_data_reg <= ctr_new;
        end
    end

    always_comb begin
        if (fwd_vld_reg && fwd_addr_reg == s1_item_reg.dst_node) begin
            ctr_cur = fwd_data_reg;
        end else if (ctr_vld_reg[s1_item_reg.dst_node]) begin
            ctr_cur = ctr_rd_reg;
        end else begin
            ctr_cur = '0;
        end
    end

    assign ctr_new = ctr_cur + 1'b1;

    // ---------------------------------------------------------------------
    // Packet state and frame packing
    // ---------------------------------------------------------------------
    logic [cpf_pkg::DATA_W-1:0] buf_reg, buf_next;
    logic [cpf_pkg::CNT_W-1:0]  buf_cnt_reg, buf_cnt_next;
    logic [cpf_pkg::FRAG_W-1:0] frag_reg, frag_next;
    logic [cpf_pkg::ID_W-1:0]   id_base_reg, id_base_next;
    logic [cpf_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [31:0]                ck_reg, ck_next;
    logic                       busy_reg, busy_next;

    logic                       is_begin;
    logic                       act;
    logic                       fin;
    logic [7:0]                 hdr0;
    logic [cpf_pkg::ID_W-1:0]   idb;
    logic [cpf_pkg::FRAG_W-1:0] fcur;
    logic [cpf_pkg::FRAG_W-1:0] fcur_p1;
    logic [cpf_pkg::DATA_W-1:0] pb;
    logic [cpf_pkg::CNT_W-1:0]  pc_cnt;
    logic [cpf_pkg::CNT_W-1:0]  tot;
    logic [31:0]                ck;
    logic [31:0]                ck_sw;
    logic [cpf_pkg::REM_W-1:0]  rem_new;
    logic [cpf_pkg::EXT_W-1:0]  ext;
    logic [1:0]                 push_cnt;
    cpf_pkg::cpf_frame_t        beat_a, beat_b, beat_out;

    assign is_begin = (s1_op_reg == cpf_pkg::OP_BEGIN);
    // stray begins (while busy) and stray bytes (while idle) drop out here
    assign act      = s1_fire && (is_begin ? !busy_reg : busy_reg);
    assign hdr0     = {s1_item_reg.flags, cpf_pkg::HLEN, s1_item_reg.ttl};
    assign fcur_p1  = fcur + 1'b1;
    // CRC goes out MSB first: byte-swap so its top byte lands in the lowest lane, sent first
    assign ck_sw    = {ck[7:0], ck[15:8], ck[23:16], ck[31:24]};
    assign ext      = {{(cpf_pkg::EXT_W - cpf_pkg::DATA_W){1'b0}}, pb}
                      | ({{(cpf_pkg::EXT_W - 32){1'b0}}, ck_sw} << {pc_cnt, 3'b000});
    assign tot      = pc_cnt + cpf_pkg::CNT_W'(cpf_pkg::CK_BYTES);

    // operands for this beat: begin starts from the header, a byte from the buffer
    always_comb begin
        if (is_begin) begin
            idb     = {s1_item_reg.src_node, s1_item_reg.priority_req,
                       s1_item_reg.dst_node, 1'b0, ctr_new, {cpf_pkg::FRAG_W{1'b0}}};
            fcur    = '0;
            pb      = {{(cpf_pkg::DATA_W - 24){1'b0}},
                       s1_item_reg.dport, s1_item_reg.sport, hdr0};
            pc_cnt  = cpf_pkg::CNT_W'(cpf_pkg::HDR_BYTES);
            ck      = s1_item_reg.checksum;
            if (int'(s1_item_reg.pay_len) > cpf_pkg::MAX_PAYLOAD) begin
                rem_new = cpf_pkg::REM_W'(cpf_pkg::MAX_PAYLOAD);
            end else begin
                rem_new = cpf_pkg::REM_W'(s1_item_reg.pay_len);
            end
            fin     = (s1_item_reg.pay_len == '0);
        end else begin
            idb     = id_base_reg;
            fcur    = frag_reg;
            pb      = buf_reg | ({{(cpf_pkg::DATA_W - 8){1'b0}}, s1_item_reg.payload_byte}
                               << {buf_cnt_reg[2:0], 3'b000});
            pc_cnt  = buf_cnt_reg + 1'b1;
            ck      = ck_reg;
            rem_new = rem_reg - cpf_pkg::REM_W'(rem_reg != '0);
            fin     = (rem_new == '0);
        end
    end

    always_comb begin
        buf_next     = buf_reg;
        buf_cnt_next = buf_cnt_reg;
        frag_next    = frag_reg;
        id_base_next = id_base_reg;
        rem_next     = rem_reg;
        ck_next      = ck_reg;
        busy_next    = busy_reg;
        ctr_wr_en    = 1'b0;
        push_cnt     = 2'd0;
        beat_a       = '0;
        beat_b       = '0;
        if (act) begin
            ctr_wr_en    = is_begin;
            id_base_next = idb;
            ck_next      = ck;
            if (fin) begin
                // CRC appended; 12 bytes at most, so one or two frames
                if (tot > cpf_pkg::CNT_W'(cpf_pkg::FRAME_BYTES)) begin
                    beat_a.frame_id     = idb | cpf_pkg::ID_W'(fcur);
                    beat_a.frame_data   = ext[cpf_pkg::DATA_W-1:0];
                    beat_a.frame_length = cpf_pkg::LEN_W'(cpf_pkg::FRAME_BYTES);
                    beat_a.last_of_run  = 1'b0;
                    beat_b.frame_id     = idb | cpf_pkg::END_BIT | cpf_pkg::ID_W'(fcur_p1);
                    beat_b.frame_data   = cpf_pkg::DATA_W'(ext[cpf_pkg::EXT_W-1:cpf_pkg::DATA_W]);
                    beat_b.frame_length = cpf_pkg::LEN_W'(tot
                                          - cpf_pkg::CNT_W'(cpf_pkg::FRAME_BYTES));
                    beat_b.last_of_run  = 1'b1;
                    push_cnt            = 2'd2;
                    frag_next           = fcur + cpf_pkg::FRAG_W'(2);
                end else begin
                    beat_a.frame_id     = idb | cpf_pkg::END_BIT | cpf_pkg::ID_W'(fcur);
                    beat_a.frame_data   = ext[cpf_pkg::DATA_W-1:0];
                    beat_a.frame_length = cpf_pkg::LEN_W'(tot);
                    beat_a.last_of_run  = 1'b1;
                    push_cnt            = 2'd1;
                    frag_next           = fcur_p1;
                end
                buf_next     = '0;
                buf_cnt_next = '0;
                rem_next     = '0;
                busy_next    = 1'b0;
            end else if (pc_cnt == cpf_pkg::CNT_W'(cpf_pkg::FRAME_BYTES)) begin
                beat_a.frame_id     = idb | cpf_pkg::ID_W'(fcur);
                beat_a.frame_data   = pb;
                beat_a.frame_length = cpf_pkg::LEN_W'(cpf_pkg::FRAME_BYTES);
                beat_a.last_of_run  = 1'b1;
                push_cnt            = 2'd1;
                frag_next           = fcur_p1;
                buf_next            = '0;
                buf_cnt_next        = '0;
                rem_next            = rem_new;
                busy_next           = 1'b1;
            end else begin
                buf_next     = pb;
                buf_cnt_next = pc_cnt;
                frag_next    = fcur;
                rem_next     = rem_new;
                busy_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            buf_cnt_reg <= '0;
            frag_reg    <= '0;
            id_base_reg <= '0;
            rem_reg     <= '0;
            ck_reg      <= '0;
            busy_reg    <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            buf_cnt_reg <= buf_cnt_next;
            frag_reg    <= frag_next;
            id_base_reg <= id_base_next;
            rem_reg     <= rem_next;
            ck_reg      <= ck_next;
            busy_reg    <= busy_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result queue; parts the packing stage from the frame consumer
    // ---------------------------------------------------------------------
    cpf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_a    (beat_a),
        .push_b    (beat_b),
        .room      (fifo_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (beat_out)
    );

    assign m_tdata = {{(cpf_pkg::M_TDATA_W - cpf_pkg::ID_W - cpf_pkg::DATA_W
                        - cpf_pkg::LEN_W){1'b0}},
                      beat_out.frame_length, beat_out.frame_data, beat_out.frame_id};
    assign m_tlast = beat_out.last_of_run;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `CPF_ASSERT(a_busy_rem, aclk, aresetn, busy_reg |-> (rem_reg != '0), "busy with no bytes")
    `CPF_ASSERT(a_idle_empty, aclk, aresetn, !busy_reg |-> (buf_cnt_reg == '0), "idle with bytes")
    `CPF_ASSERT_NEVER(a_full_shown, aclk, aresetn, !fifo_room && !m_tvalid, "full and no frame")

endmodule

// ===== verif/can_packet_fragmenter_core_tb.sv =====
// Self-checking testbench for the CAN packet fragmenter core.
`timescale 1ns / 100ps

// Tracks packet state, predicts the CAN frames each accepted beat produces and checks them.
class frame_scoreboard;
    bit [cpf_pkg::CTR_W-1:0]  dest_pkt_cnt [cpf_pkg::DST_DEPTH];
    bit [cpf_pkg::DATA_W-1:0] frame_acc;
    int unsigned              acc_count;
    bit [cpf_pkg::FRAG_W-1:0] frag_idx;
    bit [cpf_pkg::ID_W-1:0]   id_base;
    int unsigned              bytes_left;
    bit [31:0]                crc_hold;
    bit                       in_packet;
    cpf_pkg::cpf_frame_t      pending_frames[$];
    int                       errors;

    function void emit_frame(bit closing);
        cpf_pkg::cpf_frame_t f;
        f.frame_id     = id_base | cpf_pkg::ID_W'(frag_idx)
                         | (closing ? cpf_pkg::END_BIT : '0);
        f.frame_data   = frame_acc;
        f.frame_length = cpf_pkg::LEN_W'(acc_count);
        f.last_of_run  = 1'b0;
        pending_frames.push_back(f);
        frag_idx  = frag_idx + 1'b1;
        frame_acc = '0;
        acc_count = 0;
    endfunction

    function void push_octet(bit [7:0] b, bit final_b);
        frame_acc[8*acc_count +: 8] = b;
        acc_count++;
        if (acc_count >= cpf_pkg::FRAME_BYTES || final_b) begin
            emit_frame(final_b);
        end
    endfunction

    // CRC goes out MSB first; its last byte closes the packet.
    function void flush_crc();
        for (int i = 0; i < cpf_pkg::CK_BYTES; i++) begin
            push_octet(crc_hold[31-8*i -: 8], i == cpf_pkg::CK_BYTES - 1);
        end
        in_packet  = 1'b0;
        bytes_left = 0;
    endfunction

    function void note_input(cpf_pkg::cpf_op_t op, cpf_pkg::cpf_item_t it);
        int unsigned             first_new;
        int unsigned             len;
        bit [cpf_pkg::CTR_W-1:0] pc;
        cpf_pkg::cpf_frame_t     tail;
        first_new = pending_frames.size();
        if (op == cpf_pkg::OP_BEGIN) begin
            if (!in_packet) begin
                pc = dest_pkt_cnt[it.dst_node] + 1'b1;
                dest_pkt_cnt[it.dst_node] = pc;
                id_base   = {it.src_node, it.priority_req, it.dst_node, 1'b0, pc, 7'd0};
                frag_idx  = '0;
                frame_acc = '0;
                acc_count = 0;
                crc_hold  = it.checksum;
                len = it.pay_len;
                if (len > cpf_pkg::MAX_PAYLOAD) begin
                    len = cpf_pkg::MAX_PAYLOAD;
                end
                push_octet({it.flags, cpf_pkg::HLEN, it.ttl}, 1'b0);
                push_octet(it.sport, 1'b0);
                push_octet(it.dport, 1'b0);
                in_packet  = 1'b1;
                bytes_left = len;
                if (len == 0) begin
                    flush_crc();
                end
            end
        end else if (in_packet) begin
            push_octet(it.payload_byte, 1'b0);
            if (bytes_left > 0) begin
                bytes_left--;
            end
            if (bytes_left == 0) begin
                flush_crc();
            end
        end
        if (pending_frames.size() > first_new) begin
            tail = pending_frames.pop_back();
            tail.last_of_run = 1'b1;
            pending_frames.push_back(tail);
        end
    endfunction

    function void check_frame(cpf_pkg::cpf_frame_t got);
        cpf_pkg::cpf_frame_t want;
        if (pending_frames.size() == 0) begin
            $error("unexpected frame: frame_id %h frame_data %h", got.frame_id, got.frame_data);
            errors++;
            return;
        end
        want = pending_frames.pop_front();
        if (got.frame_id !== want.frame_id) begin
            $error("frame_id expected %h actual %h", want.frame_id, got.frame_id);
            errors++;
        end
        if (got.frame_data !== want.frame_data) begin
            $error("frame_data expected %h actual %h", want.frame_data, got.frame_data);
            errors++;
        end
        if (got.frame_length !== want.frame_length) begin
            $error("frame_length expected %0d actual %0d", want.frame_length, got.frame_length);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0d actual %0d", want.last_of_run, got.last_of_run);
            errors++;
        end
    endfunction
endclass

module can_packet_fragmenter_core_tb;

    localparam int RX_HOLD_CYCLES = 200;   // long receiver hold-off for the fill-up phase
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 20;    // frames pass the input register and the result queue before they appear

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cpf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cpf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    frame_scoreboard sb = new;

    int unsigned tx_idle_pct  = 0;   // chance in percent of an idle cycle before a beat
    int unsigned rx_stall_pct = 0;   // chance in percent of m_tready low in a cycle
    int unsigned items_sent   = 0;   // beats of packets, strays not counted
    int unsigned quiet_cycles = 0;
    int unsigned rx_hold_left = 0;
    bit          hold_armed   = 1'b0;
    bit          hold_taken   = 1'b0;

    can_packet_fragmenter_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both channels are sampled at the rising edge; inputs are noted before results
    // are checked, and a frame never shows in the cycle its beat is taken.
    always @(posedge aclk) begin
        cpf_pkg::cpf_frame_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(cpf_pkg::cpf_op_t'(s_tuser), cpf_pkg::cpf_item_t'(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.frame_id     = m_tdata[cpf_pkg::ID_W-1:0];
                got.frame_data   = m_tdata[cpf_pkg::ID_W +: cpf_pkg::DATA_W];
                got.frame_length = m_tdata[cpf_pkg::ID_W+cpf_pkg::DATA_W +: cpf_pkg::LEN_W];
                got.last_of_run  = m_tlast;
                sb.check_frame(got);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when the fill-up phase arms it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken   <= 1'b1;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: a stuck handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[can_packet_fragmenter_core] ERROR");
            $finish;
        end
    end

    function automatic cpf_pkg::cpf_item_t rand_item();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return cpf_pkg::cpf_item_t'(raw[cpf_pkg::S_TDATA_W-1:0]);
    endfunction

    function automatic cpf_pkg::cpf_item_t begin_item(input logic [7:0] src,
                                                      input logic [7:0] dst,
                                                      input logic [1:0] prio,
                                                      input logic [1:0] flg,
                                                      input logic [3:0] ttl_v,
                                                      input logic [7:0] sp,
                                                      input logic [7:0] dp,
                                                      input logic [7:0] plen,
                                                      input logic [31:0] crc);
        cpf_pkg::cpf_item_t it;
        it = rand_item();
        it.src_node     = src;
        it.dst_node     = dst;
        it.priority_req = prio;
        it.flags        = flg;
        it.ttl          = ttl_v;
        it.sport        = sp;
        it.dport        = dp;
        it.pay_len      = plen;
        it.checksum     = crc;
        return it;
    endfunction

    function automatic cpf_pkg::cpf_item_t data_item(input logic [7:0] b);
        cpf_pkg::cpf_item_t it;
        it = rand_item();
        it.payload_byte = b;
        return it;
    endfunction

    // Offer one beat, with random idle cycles ahead of it; returns once it is taken.
    task automatic send_beat(input cpf_pkg::cpf_op_t op, input cpf_pkg::cpf_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= it;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // One packet with random content. Rarely a stray begin lands mid-packet (ignored
    // while busy) or the packet is cut short, which throws the next one out of step.
    task automatic send_packet(input int unsigned len);
        cpf_pkg::cpf_item_t it;
        it = rand_item();
        it.pay_len = 8'(len);
        if ($urandom_range(1) == 1) begin
            it.dst_node = 8'($urandom_range(3));   // few destinations so counters wrap
        end
        send_beat(cpf_pkg::OP_BEGIN, it);
        items_sent++;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(99) < 2) begin
                send_beat(cpf_pkg::OP_BEGIN, rand_item());
            end
            if ($urandom_range(299) == 0) begin
                break;
            end
            send_beat(cpf_pkg::OP_DATA, rand_item());
            items_sent++;
        end
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned n_items);
        int unsigned target;
        int unsigned w;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            w = $urandom_range(99);
            if (w < 4) begin
                send_beat(cpf_pkg::OP_DATA, rand_item());   // stray payload beat between packets
            end else if (w < 64) begin
                send_packet($urandom_range(12));
            end else if (w < 96) begin
                send_packet($urandom_range(48, 13));
            end else begin
                send_packet($urandom_range(255, 49));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: all-zero begin with no payload gives a lone 7-byte end frame.
        send_beat(cpf_pkg::OP_BEGIN, begin_item(8'h00, 8'h00, 2'd0, 2'd0, 4'h0, 8'h00, 8'h00,
                                                8'd0, 32'h0000_0000));
        // All fields but the length at maximum; the last payload byte spills the CRC into two frames.
        send_beat(cpf_pkg::OP_BEGIN, begin_item(8'hFF, 8'hFF, 2'd3, 2'd3, 4'hF, 8'hFF, 8'hFF,
                                                8'd2, 32'hFFFF_FFFF));
        send_beat(cpf_pkg::OP_DATA, data_item(8'hFF));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h00));
        // Payload beat while idle: dropped.
        send_beat(cpf_pkg::OP_DATA, data_item(8'hA5));
        // Header plus payload fills the first frame exactly; a begin mid-packet is dropped.
        send_beat(cpf_pkg::OP_BEGIN, begin_item(8'h12, 8'h34, 2'd1, 2'd2, 4'h9, 8'h56, 8'h78,
                                                8'd5, 32'h0123_4567));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h01));
        send_beat(cpf_pkg::OP_BEGIN, begin_item(8'h9A, 8'h34, 2'd2, 2'd1, 4'h3, 8'hBC, 8'hDE,
                                                8'd0, 32'h89AB_CDEF));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h02));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h03));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h04));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h05));
        // One payload byte: header, byte and CRC make exactly one full end frame.
        send_beat(cpf_pkg::OP_BEGIN, begin_item(8'h3C, 8'hC3, 2'd2, 2'd1, 4'h6, 8'h5A, 8'hA5,
                                                8'd1, 32'hDEAD_BEEF));
        send_beat(cpf_pkg::OP_DATA, data_item(8'h7E));
        // Nine packets to one destination: the 3-bit packet counter wraps.
        for (int i = 0; i < 9; i++) begin
            send_beat(cpf_pkg::OP_BEGIN,
                      begin_item(8'($urandom), 8'h55, 2'($urandom), 2'($urandom),
                                 4'($urandom), 8'($urandom), 8'($urandom), 8'd0,
                                 $urandom));
        end

        // Longest packet once, then random traffic under each idling mix.
        send_packet(255);
        run_phase(0, 0, 300);
        run_phase(88, 0, 300);
        run_phase(0, 88, 300);
        run_phase(35, 35, 300);

        // Receiver holds off for a long stretch while beats keep coming, so the
        // result queue fills and s_tready drops.
        hold_armed = 1'b1;
        run_phase(0, 0, 150);

        s_tvalid <= 1'b0;
        while (sb.pending_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
            $display("[can_packet_fragmenter_core] OK");
        end else begin
            $display("[can_packet_fragmenter_core] ERROR");
        end
        $finish;
    end

endmodule
